### hdl/assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_PROP(label, clk, rst_n, !(cond), msg)

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

### hdl/brf_pkg.sv
package brf_pkg;

    localparam int DEPTH_DEFAULT = 4096;

    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 13;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP        = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REQUEUE    = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [BYTE_W-1:0]  data_in;
        logic [COUNT_W-1:0] requeue_count;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]  data_out;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] fill_count;
    } t_out_item;

endpackage

### hdl/brf_ram.sv
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/byte_ring_fifo_with_unread.sv
// Byte ring deque with requeue.
// Input channel (i_in_valid / o_in_ready, i_in_item) carries one command per
// item: push back, push front, pop, clear or requeue. Every accepted item
// yields exactly one result item on the output channel (o_out_valid /
// i_out_ready, o_out_item) with the popped byte, a status code and the fill
// count after the command.
// A result passes through the result stage and then the output register.
// Throughput: one item per cycle while the receiver does not stall; the byte
// store is a single-port-write, single-port-read RAM with a registered read,
// and pointers and count are updated in the accept cycle, so commands follow
// each other without gaps. A pop issues its RAM read in the accept cycle; the
// data lands in a result stage next to the output register.
// Reset clears pointers, fill count and all valid flags; the byte store is
// not cleared and needs no clearing pass.
// When the receiver stalls, the output register holds its item, the result
// stage fills, and then o_in_ready drops until the output drains.
module byte_ring_fifo_with_unread #(
    parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  brf_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output brf_pkg::t_out_item o_out_item
);

`include "assert_macros.svh"

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = ((CW > brf_pkg::COUNT_W) ? CW : brf_pkg::COUNT_W) + 1;

    localparam logic [PW-1:0] PTR_LAST  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL  = CW'(DEPTH);
    localparam logic [SW-1:0] SUM_DEPTH = SW'(DEPTH);

    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    logic                       r_s1_valid, n_s1_valid;
    logic                       r_s1_pop;
    logic [brf_pkg::STAT_W-1:0] r_s1_status;
    logic [CW-1:0]              r_s1_cnt;

    logic               r_out_valid;
    brf_pkg::t_out_item r_out_item;

    logic accept;
    logic out_free;
    logic s1_adv;
    logic full;
    logic empty;

    logic [PW-1:0] wp_next;
    logic [PW-1:0] rp_next;
    logic [PW-1:0] rp_prev;
    logic [SW-1:0] rq_sum;
    logic          rq_over;
    logic [SW-1:0] rq_raw;
    logic [SW-1:0] rq_wrap;

    logic                       ram_we;
    logic [PW-1:0]              ram_waddr;
    logic                       ram_re;
    logic [brf_pkg::BYTE_W-1:0] ram_rdata;
    logic                       pop_ok;
    logic [brf_pkg::STAT_W-1:0] status;

    logic [CW-1:0] ptr_dist;
    logic [CW-1:0] cnt_mod;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign s1_adv     = r_s1_valid && out_free;

    assign full  = (r_cnt == CNT_FULL);
    assign empty = (r_cnt == '0);

    assign wp_next = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
    assign rp_next = (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
    assign rp_prev = (r_rp == '0) ? PTR_LAST : r_rp - 1'b1;

    // tail steps back by the count, modulo depth
    assign rq_sum  = SW'(r_cnt) + SW'(i_in_item.requeue_count);
    assign rq_over = (rq_sum > SUM_DEPTH);
    assign rq_raw  = SW'(r_rp) + SUM_DEPTH - SW'(i_in_item.requeue_count);
    assign rq_wrap = (rq_raw >= SUM_DEPTH) ? rq_raw - SUM_DEPTH : rq_raw;

    always_comb begin
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_cnt     = r_cnt;
        ram_we    = 1'b0;
        ram_waddr = r_wp;
        ram_re    = 1'b0;
        pop_ok    = 1'b0;
        status    = brf_pkg::STAT_OK;
        case (i_in_item.command)
            brf_pkg::CMD_PUSH_BACK: begin
                if (full) begin
                    status = brf_pkg::STAT_FULL;
                end else begin
                    ram_we    = accept;
                    ram_waddr = r_wp;
                    n_wp      = wp_next;
                    n_cnt     = r_cnt + 1'b1;
                end
            end
            brf_pkg::CMD_PUSH_FRONT: begin
                if (full) begin
                    status = brf_pkg::STAT_FULL;
                end else begin
                    ram_we    = accept;
                    ram_waddr = rp_prev;
                    n_rp      = rp_prev;
                    n_cnt     = r_cnt + 1'b1;
                end
            end
            brf_pkg::CMD_POP: begin
                if (empty) begin
                    status = brf_pkg::STAT_EMPTY;
                end else begin
                    ram_re = accept;
                    pop_ok = 1'b1;
                    n_rp   = rp_next;
                    n_cnt  = r_cnt - 1'b1;
                end
            end
            brf_pkg::CMD_CLEAR: begin
                n_rp  = r_wp;
                n_cnt = '0;
            end
            brf_pkg::CMD_REQUEUE: begin
                if (rq_over) begin
                    status = brf_pkg::STAT_OVERFLOW;
                end else begin
                    n_rp  = rq_wrap[PW-1:0];
                    n_cnt = rq_sum[CW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    brf_ram #(
        .WIDTH (brf_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in_item.data_in),
        .i_re    (ram_re),
        .i_raddr (r_rp),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_cnt       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (accept) begin
                r_wp  <= n_wp;
                r_rp  <= n_rp;
                r_cnt <= n_cnt;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pop    <= pop_ok;
            r_s1_status <= status;
            r_s1_cnt    <= n_cnt;
        end
        if (s1_adv) begin
            r_out_item.data_out   <= r_s1_pop ? ram_rdata : '0;
            r_out_item.status     <= r_s1_status;
            r_out_item.fill_count <= brf_pkg::COUNT_W'(r_s1_cnt);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // head minus tail, modulo depth, must match the fill count modulo depth
    assign ptr_dist = (r_wp >= r_rp) ? CW'(r_wp) - CW'(r_rp)
                                     : CW'(r_wp) + CNT_FULL - CW'(r_rp);
    assign cnt_mod  = full ? '0 : r_cnt;

    `ASSERT_PROP(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_FULL,
        "fill count above depth")
    `ASSERT_PROP(a_ptr_consistent, i_clk, i_rst_n, ptr_dist == cnt_mod,
        "pointers disagree with fill count")
    `ASSERT_PROP(a_accept_to_s1, i_clk, i_rst_n, accept |=> r_s1_valid,
        "accepted item lost before result stage")
    `ASSERT_PROP(a_reject_keeps, i_clk, i_rst_n,
        accept && full && (i_in_item.command == brf_pkg::CMD_PUSH_BACK ||
        i_in_item.command == brf_pkg::CMD_PUSH_FRONT) |=> $stable(r_cnt),
        "rejected push changed fill count")

endmodule

### tb/byte_ring_fifo_with_unread_tb.sv
module byte_ring_fifo_with_unread_tb;

    localparam int DEPTH       = brf_pkg::DEPTH_DEFAULT;
    localparam int CMD_W       = brf_pkg::CMD_W;
    localparam int BYTE_W      = brf_pkg::BYTE_W;
    localparam int COUNT_W     = brf_pkg::COUNT_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    brf_pkg::t_in_item  i_in_item;
    logic               o_out_valid;
    logic               i_out_ready;
    brf_pkg::t_out_item o_out_item;

    bit steady;
    bit hold_request;
    int hold_left;
    int cycle_count;

    class deque_scoreboard;
        logic [BYTE_W-1:0]  ring_bytes [DEPTH];
        bit                 ever_written [DEPTH];
        int unsigned        head;
        int unsigned        tail;
        int unsigned        held;
        brf_pkg::t_out_item expected_results [$];
        int                 errors;

        function bit pop_hits_unwritten();
            return held != 0 && !ever_written[tail];
        endfunction

        function void note_command(brf_pkg::t_in_item it);
            brf_pkg::t_out_item r;
            r = '0;
            r.status = brf_pkg::STAT_OK;
            case (it.command)
                brf_pkg::CMD_PUSH_BACK: begin
                    if (held >= DEPTH) begin
                        r.status = brf_pkg::STAT_FULL;
                    end else begin
                        ring_bytes[head] = it.data_in;
                        ever_written[head] = 1'b1;
                        head = (head + 1) % DEPTH;
                        held++;
                    end
                end
                brf_pkg::CMD_PUSH_FRONT: begin
                    if (held >= DEPTH) begin
                        r.status = brf_pkg::STAT_FULL;
                    end else begin
                        tail = (tail + DEPTH - 1) % DEPTH;
                        ring_bytes[tail] = it.data_in;
                        ever_written[tail] = 1'b1;
                        held++;
                    end
                end
                brf_pkg::CMD_POP: begin
                    if (held == 0) begin
                        r.status = brf_pkg::STAT_EMPTY;
                    end else begin
                        r.data_out = ring_bytes[tail];
                        tail = (tail + 1) % DEPTH;
                        held--;
                    end
                end
                brf_pkg::CMD_CLEAR: begin
                    tail = head;
                    held = 0;
                end
                brf_pkg::CMD_REQUEUE: begin
                    if (held + it.requeue_count > DEPTH) begin
                        r.status = brf_pkg::STAT_OVERFLOW;
                    end else begin
                        tail = (tail + DEPTH - it.requeue_count) % DEPTH;
                        held += it.requeue_count;
                    end
                end
                default: begin
                end
            endcase
            r.fill_count = COUNT_W'(held);
            expected_results.push_back(r);
        endfunction

        function void check_result(brf_pkg::t_out_item got);
            brf_pkg::t_out_item want;
            if (expected_results.size() == 0) begin
                $error("result with no command outstanding: %0h", got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.data_out !== want.data_out) begin
                $error("data_out: expected %0h, got %0h", want.data_out, got.data_out);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.fill_count !== want.fill_count) begin
                $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
                errors++;
            end
        endfunction
    endclass

    deque_scoreboard sb;

    byte_ring_fifo_with_unread dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic brf_pkg::t_in_item cmd_item(logic [CMD_W-1:0] cmd,
                                                   logic [BYTE_W-1:0] data,
                                                   logic [COUNT_W-1:0] cnt);
        brf_pkg::t_in_item it;
        it.command       = cmd;
        it.data_in       = data;
        it.requeue_count = cnt;
        return it;
    endfunction

    function automatic brf_pkg::t_in_item random_command();
        brf_pkg::t_in_item it;
        int pick;
        int shape;
        pick  = $urandom_range(0, 99);
        shape = $urandom_range(0, 99);
        it.data_in       = BYTE_W'($urandom);
        it.requeue_count = COUNT_W'($urandom);
        if (pick < 30) begin
            it.command = brf_pkg::CMD_PUSH_BACK;
        end else if (pick < 40) begin
            it.command = brf_pkg::CMD_PUSH_FRONT;
        end else if (pick < 72) begin
            it.command = brf_pkg::CMD_POP;
        end else if (pick < 75) begin
            it.command = brf_pkg::CMD_CLEAR;
        end else if (pick < 95) begin
            it.command = brf_pkg::CMD_REQUEUE;
            if (shape < 60) begin
                it.requeue_count = COUNT_W'($urandom_range(0, 8));
            end else if (shape < 75) begin
                // exact fill up to full
                it.requeue_count = COUNT_W'(DEPTH - sb.held);
            end else if (shape < 90) begin
                it.requeue_count = COUNT_W'($urandom_range(0, DEPTH));
            end else begin
                it.requeue_count = COUNT_W'($urandom_range(0, (1 << COUNT_W) - 1));
            end
        end else begin
            it.command = CMD_W'($urandom_range(brf_pkg::CMD_REQUEUE + 1, (1 << CMD_W) - 1));
        end
        return it;
    endfunction

    task automatic send_item(input brf_pkg::t_in_item it);
        // never pop a store entry that was never written
        if (it.command == brf_pkg::CMD_POP && sb.pop_hits_unwritten()) begin
            it.command = brf_pkg::CMD_PUSH_FRONT;
        end
        while (!steady && $urandom_range(0, 99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        sb.note_command(it);
    endtask

    // receiver
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready) begin
                sb.check_result(o_out_item);
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= steady || $urandom_range(0, 99) >= 34;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        sb = new;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_item(cmd_item(brf_pkg::CMD_POP, 8'h00, '0));
        send_item(cmd_item(brf_pkg::CMD_PUSH_BACK, 8'h00, '0));
        send_item(cmd_item(brf_pkg::CMD_PUSH_BACK, 8'hff, '0));
        send_item(cmd_item(brf_pkg::CMD_PUSH_FRONT, 8'ha5, '0));
        repeat (4) send_item(cmd_item(brf_pkg::CMD_POP, 8'h00, '0));
        send_item(cmd_item(brf_pkg::CMD_REQUEUE, 8'h00, '0));
        send_item(cmd_item(brf_pkg::CMD_REQUEUE, 8'h00, COUNT_W'(3)));
        send_item(cmd_item(brf_pkg::CMD_POP, 8'h00, '0));
        send_item(cmd_item(brf_pkg::CMD_PUSH_BACK, 8'h5a, '0));
        for (int c = brf_pkg::CMD_REQUEUE + 1; c < (1 << CMD_W); c++) begin
            send_item(cmd_item(CMD_W'(c), 8'hff, {COUNT_W{1'b1}}));
        end
        send_item(cmd_item(brf_pkg::CMD_CLEAR, 8'h00, '0));
        send_item(cmd_item(brf_pkg::CMD_REQUEUE, 8'h00, COUNT_W'(DEPTH)));
        send_item(cmd_item(brf_pkg::CMD_PUSH_BACK, 8'hc3, '0));
        send_item(cmd_item(brf_pkg::CMD_PUSH_FRONT, 8'h3c, '0));
        send_item(cmd_item(brf_pkg::CMD_REQUEUE, 8'h00, COUNT_W'(1)));
        send_item(cmd_item(brf_pkg::CMD_REQUEUE, 8'h00, {COUNT_W{1'b1}}));
        send_item(cmd_item(brf_pkg::CMD_CLEAR, 8'h00, '0));

        repeat (200) send_item(random_command());

        steady = 1'b1;
        repeat (100) send_item(random_command());

        // receiver backs off while the sender keeps going
        hold_request = 1'b1;
        repeat (40) send_item(random_command());
        steady = 1'b0;

        repeat (160) send_item(random_command());
        i_in_valid <= 1'b0;

        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (sb.expected_results.size() != 0) begin
            $error("results still outstanding: %0d", sb.expected_results.size());
        end
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### byte_ring_fifo_with_unread.f
+incdir+hdl
hdl/brf_pkg.sv
hdl/brf_ram.sv
hdl/byte_ring_fifo_with_unread.sv
tb/byte_ring_fifo_with_unread_tb.sv
